// ----- hdl/sem_pkg.sv -----
// Shared constants, types and helpers for the Sobel edge magnitude block.
package sem_pkg;

   // Line store depth, frame height limit and the counter and field widths that follow from them
   localparam int MAX_ROW_PIXELS = 2048;
   localparam int MAX_FRAME_ROWS = 4096;
   localparam int ADDR_W         = $clog2(MAX_ROW_PIXELS);
   localparam int PIX_W          = 8;
   localparam int COL_W          = 11;
   localparam int ROW_W          = 12;
   localparam int WID_W          = 12;
   localparam int HGT_W          = 13;
   localparam int CSR_W          = 13;
   localparam int EXT_W          = $clog2(MAX_ROW_PIXELS) + 2;
   localparam int GRAD_W         = 12;
   localparam int SQ_W           = 20;
   localparam int ENERGY_W       = 21;
   localparam int ROOT_W         = 17;
   localparam int STEP_W         = 3;
   localparam int SQRT_STEPS     = 8;
   localparam int RSP_DATA_W     = 32;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);
   localparam logic [PIX_W-1:0] MAG_SAT      = PIX_W'(255);

   // Configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              accept;
      logic              fetch;
      logic              mul;
      logic              sum;
      logic              sqrt_step;
      logic [STEP_W-1:0] step;
      logic              load_out;
   } cmd_type;

   // Status from the datapath back to the controller
   typedef struct packed {
      logic emit;
      logic out_free;
   } sts_type;

endpackage

// ----- hdl/sobel_edge_magnitude_top.sv -----
// Top level of the 3x3 Sobel edge magnitude block over a raster pixel stream.
// Flow: an accepted pixel is fetched and, if it completes an interior window, squared,
//   summed, rooted and emitted; a border pixel finishes after the fetch and gives no result.
// A new pixel is taken only once the last one is through; the root uses the
//   8-step shared square-root iteration, and emitting waits for a free result register.
// Reset (synchronous, active high) clears counters, window and result valid; the size
//   registers return to 640 x 480. Line stores keep whatever they hold until written.
module sobel_edge_magnitude_top (
   input  logic                           clock,
   input  logic                           reset,
   // Pixel requests
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sem_pkg::PIX_W-1:0]      req_tdata,  // [7:0] pixel
   input  logic                           req_tuser,  // [0] frame_start
   // Results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sem_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [7:0] magnitude, [18:8] centre_x,
                                                      // [30:19] centre_y, [31] zero
   output logic                           rsp_tlast,  // frame_last
   // Configuration: index 0 frame_width, index 1 frame_height
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [sem_pkg::CSR_W-1:0]      csr_wdata
);
   import sem_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller: hold ready low while a request is in flight, step the root iteration
   sem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: advance the position, fetch and update the line stores, compute
   // the gradient energy and its saturated root, and drop it into the result register
   sem_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .pixel       (req_tdata),
      .frame_start (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ----- hdl/sem_ctrl.sv -----
// Controller state machine that sequences one pixel request through the datapath.
module sem_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sem_pkg::sts_type sts,
   output sem_pkg::cmd_type cmd
);
   import sem_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_SUM,
      ST_SQRT,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic              ready_ff;
   logic [STEP_W-1:0] step_ff;
   logic              accept;

   assign accept     = req_tvalid & ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.fetch     = (state_ff == ST_FETCH);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.sum       = (state_ff == ST_SUM);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.step      = step_ff;
      cmd.load_out  = (state_ff == ST_EMIT) & sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_FETCH;
                  ready_ff <= 1'b0;
               end
            end
            ST_FETCH: begin
               if (sts.emit) begin
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_MUL: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_SQRT;
               step_ff  <= '0;
            end
            ST_SQRT: begin
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  state_ff <= ST_EMIT;
               end
               step_ff <= step_ff + STEP_W'(1);
            end
            ST_EMIT: begin
               if (sts.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ----- hdl/sem_dp.sv -----
// Datapath: position counters, line stores, window, Sobel sums, square root, result register.
module sem_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  sem_pkg::cmd_type            cmd,
   output sem_pkg::sts_type            sts,
   input  logic [sem_pkg::PIX_W-1:0]   pixel,
   input  logic                        frame_start,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [sem_pkg::CSR_W-1:0]   csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sem_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);
   import sem_pkg::*;

   // Configuration
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [EXT_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;

   // Position
   logic [COL_W-1:0] col_ff, col;
   logic [ROW_W-1:0] row_ff, row;
   logic [EXT_W-1:0] col_ext;
   logic [HGT_W-1:0] row_ext;
   logic             col_last, row_last, emit_in;
   logic [EXT_W-1:0] idx_full;

   // Request held for the duration of its work
   logic [PIX_W-1:0]  pix_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic              emit_ff;
   logic              last_ff;
   logic [COL_W-1:0]  cx_ff;
   logic [ROW_W-1:0]  cy_ff;

   // Line stores and window
   logic [PIX_W-1:0] store_a [MAX_ROW_PIXELS];
   logic [PIX_W-1:0] store_b [MAX_ROW_PIXELS];
   logic [PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic [PIX_W-1:0] win_ff [6];

   // Arithmetic
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [ENERGY_W-1:0]      energy;
   logic                     sat_ff;
   logic [ROOT_W-1:0]        rem_ff, root_ff, bit_val, trial;

   // Result register
   logic                  out_valid_ff;
   logic [PIX_W-1:0]      mag_ff;
   logic [COL_W-1:0]      ox_ff;
   logic [ROW_W-1:0]      oy_ff;
   logic                  olast_ff;

   // Clamp the frame size
   always_comb begin
      if (EXT_W'(width_ff) < EXT_W'(3)) begin
         w_eff = EXT_W'(3);
      end else if (EXT_W'(width_ff) > EXT_W'(MAX_ROW_PIXELS)) begin
         w_eff = EXT_W'(MAX_ROW_PIXELS);
      end else begin
         w_eff = EXT_W'(width_ff);
      end
      if (height_ff < HGT_W'(3)) begin
         h_eff = HGT_W'(3);
      end else if (height_ff > HGT_W'(MAX_FRAME_ROWS)) begin
         h_eff = HGT_W'(MAX_FRAME_ROWS);
      end else begin
         h_eff = height_ff;
      end
   end

   always_comb begin
      col      = frame_start ? '0 : col_ff;
      row      = frame_start ? '0 : row_ff;
      col_ext  = EXT_W'(col);
      row_ext  = HGT_W'(row);
      col_last = col_ext >= (w_eff - EXT_W'(1));
      row_last = row_ext >= (h_eff - HGT_W'(1));
      emit_in  = (col_ext >= EXT_W'(2)) && (row_ext >= HGT_W'(2))
               && (col_ext < w_eff) && (row_ext < h_eff);
      idx_full = (col_ext < EXT_W'(MAX_ROW_PIXELS)) ? col_ext
               : EXT_W'(MAX_ROW_PIXELS - 1);
   end

   // Configuration writes and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         emit_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[WID_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata[HGT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            emit_ff <= emit_in;
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_last ? '0 : row + ROW_W'(1);
            end else begin
               col_ff <= col + COL_W'(1);
               row_ff <= row;
            end
         end
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff  <= pixel;
         idx_ff  <= idx_full[ADDR_W-1:0];
         last_ff <= col_last & row_last;
         cx_ff   <= col - COL_W'(1);
         cy_ff   <= row - ROW_W'(1);
      end
   end

   // Line stores: read on accept, write back once the data is in hand
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_a_ff <= store_a[idx_full[ADDR_W-1:0]];
         rd_b_ff <= store_b[idx_full[ADDR_W-1:0]];
      end
      if (cmd.fetch) begin
         store_b[idx_ff] <= rd_a_ff;
         store_a[idx_ff] <= pix_ff;
      end
   end

   // Sobel sums over the window: top row win 0,1 + rd_b; middle win 2,3 + rd_a; bottom win 4,5 + pixel
   always_comb begin
      gx_in = (GRAD_W'(rd_b_ff) + (GRAD_W'(rd_a_ff) <<< 1) + GRAD_W'(pix_ff))
            - (GRAD_W'(win_ff[0]) + (GRAD_W'(win_ff[2]) <<< 1) + GRAD_W'(win_ff[4]));
      gy_in = (GRAD_W'(win_ff[0]) + (GRAD_W'(win_ff[1]) <<< 1) + GRAD_W'(rd_b_ff))
            - (GRAD_W'(win_ff[4]) + (GRAD_W'(win_ff[5]) <<< 1) + GRAD_W'(pix_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.fetch) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= rd_b_ff;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= rd_a_ff;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= pix_ff;
      end
   end

   assign energy  = ENERGY_W'(sqx_ff) + ENERGY_W'(sqy_ff);
   assign bit_val = ROOT_W'(1) << (ROOT_W'(14) - (ROOT_W'(cmd.step) << 1));
   assign trial   = root_ff + bit_val;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (cmd.mul) begin
         // widen before squaring so the full square survives
         sqx_ff <= unsigned'(SQ_W'(gx_ff) * SQ_W'(gx_ff));
         sqy_ff <= unsigned'(SQ_W'(gy_ff) * SQ_W'(gy_ff));
      end
      if (cmd.sum) begin
         sat_ff  <= energy >= ENERGY_W'(65536);
         rem_ff  <= ROOT_W'(energy[15:0]);
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_val;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mag_ff   <= sat_ff ? MAG_SAT : root_ff[PIX_W-1:0];
         ox_ff    <= cx_ff;
         oy_ff    <= cy_ff;
         olast_ff <= last_ff;
      end
   end

   assign sts.emit     = emit_ff;
   assign sts.out_free = ~out_valid_ff | rsp_tready;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {1'b0, oy_ff, ox_ff, mag_ff};
   assign rsp_tlast    = olast_ff;

endmodule

// ----- hdl/sem_checker.sv -----
// Port-level checker for the Sobel edge magnitude block, bound to the top level.
module sem_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sem_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sem_pkg::*;

   // A held result stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // One request at a time: ready falls right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   // No result appears in the cycle right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

   // Results only for interior centres, never at row or column zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:8] != 11'd0) && (rsp_tdata[30:19] != 12'd0))
      else $error("result for a border pixel");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/sobel_edge_magnitude_checker.sv -----
// Checker for the Sobel edge magnitude block: predicts each edge result and compares it.
module sobel_edge_magnitude_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [sem_pkg::PIX_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic                           req_tuser,   // [0] frame_start
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [sem_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] magnitude, [18:8] centre_x,
                                                       // [30:19] centre_y, [31] zero
   input  logic                           rsp_tlast,   // frame_last
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [sem_pkg::CSR_W-1:0]      csr_wdata,
   output int                             mismatch_count,
   output int                             edges_pending,
   output int                             edges_checked,
   output int                             pixels_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import sem_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic [COL_W-1:0] centre_x;
      logic [ROW_W-1:0] centre_y;
      logic             frame_last;
   } edge_type;

   // Result word as it sits on rsp_tdata, top bit first
   typedef struct packed {
      logic             pad;
      logic [ROW_W-1:0] centre_y;
      logic [COL_W-1:0] centre_x;
      logic [PIX_W-1:0] magnitude;
   } rsp_word_type;

   edge_type         expected_edges[$];
   logic [PIX_W-1:0] prev_row  [MAX_ROW_PIXELS];
   logic [PIX_W-1:0] older_row [MAX_ROW_PIXELS];
   logic [PIX_W-1:0] win [6];   // top, middle, bottom rows; oldest column first
   int               col_pos;
   int               row_pos;
   logic [WID_W-1:0] width_reg;
   logic [HGT_W-1:0] height_reg;
   int               fail_total;
   int               checked_total;
   int               seen_total;

   function automatic logic [PIX_W-1:0] root_sat(int energy);
      logic [PIX_W-1:0] r;
      r = '0;
      if (energy >= 65536) return MAG_SAT;
      for (int b = PIX_W - 1; b >= 0; b--) begin
         if ((int'(r) + (1 << b)) * (int'(r) + (1 << b)) <= energy)
            r = r | PIX_W'(1 << b);
      end
      return r;
   endfunction

   // Shift one pixel into the window and line stores; queue a result for an interior centre
   function automatic void predict_edge(logic [PIX_W-1:0] pix, logic sof);
      int       w, h, idx, gx, gy;
      int       t0, t1, t2, m0, m1, m2, b0, b1, b2;
      edge_type e;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(width_reg);
      h = (height_reg < 3) ? 3 :
          (height_reg > MAX_FRAME_ROWS) ? MAX_FRAME_ROWS : int'(height_reg);
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      idx = (col_pos < MAX_ROW_PIXELS) ? col_pos : MAX_ROW_PIXELS - 1;
      t0 = win[0]; t1 = win[1]; t2 = older_row[idx];
      m0 = win[2]; m1 = win[3]; m2 = prev_row[idx];
      b0 = win[4]; b1 = win[5]; b2 = pix;
      older_row[idx] = PIX_W'(m2);
      prev_row[idx]  = pix;
      win[0] = PIX_W'(t1); win[1] = PIX_W'(t2);
      win[2] = PIX_W'(m1); win[3] = PIX_W'(m2);
      win[4] = PIX_W'(b1); win[5] = pix;
      if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
         gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
         gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
         e.magnitude  = root_sat(gx * gx + gy * gy);
         e.centre_x   = COL_W'(col_pos - 1);
         e.centre_y   = ROW_W'(row_pos - 1);
         e.frame_last = (col_pos >= w - 1 && row_pos >= h - 1);
         expected_edges = {expected_edges, e};
      end
      if (col_pos >= w - 1) begin
         col_pos = 0;
         row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type got;
      edge_type     want;
      if (reset) begin
         expected_edges.delete();
         foreach (prev_row[i]) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
      end else begin
         // a request taken at this edge still sees the sizes from before any write here
         if (req_tvalid && req_tready) begin
            seen_total++;
            predict_edge(req_tdata, req_tuser);
         end
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) width_reg = csr_wdata[WID_W-1:0];
            else if (csr_index == CSR_FRAME_HEIGHT) height_reg = csr_wdata[HGT_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (expected_edges.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("[chk] %0t: unexpected result mag %0d at (%0d,%0d) last %0b",
                           $realtime, got.magnitude, got.centre_x, got.centre_y, rsp_tlast);
            end else begin
               want = expected_edges.pop_front();
               checked_total++;
               if (got.magnitude !== want.magnitude || got.centre_x !== want.centre_x ||
                   got.centre_y !== want.centre_y || got.pad !== 1'b0 ||
                   rsp_tlast !== want.frame_last) begin
                  fail_total++;
                  if (fail_total <= 10) begin
                     $display("[chk] %0t: wrong result, expected mag %0d (%0d,%0d) last %0b,",
                              $realtime, want.magnitude, want.centre_x, want.centre_y,
                              want.frame_last);
                     $display("[chk]   got mag %0d (%0d,%0d) last %0b pad %0b",
                              got.magnitude, got.centre_x, got.centre_y, rsp_tlast, got.pad);
                  end
               end
            end
         end
      end
      mismatch_count <= fail_total;
      edges_pending  <= expected_edges.size();
      edges_checked  <= checked_total;
      pixels_seen    <= seen_total;
   end

endmodule

// ----- verif/tb_sobel_edge_magnitude_top.sv -----
// Testbench top for the Sobel edge magnitude block: stimulus, flow control and verdict.
module tb_sobel_edge_magnitude_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sem_pkg::*;

   // Leave a margin after the last result before touching the size registers
   localparam int DRAIN_CYCLES  = 20;
   // Watchdog limit, with a wide margin over the slowest correct run
   localparam int RUN_LIMIT     = 200_000;
   localparam int RANDOM_PIXELS = 380;
   localparam int QUIET_FROM    = 300;
   localparam int WIDE_PIXELS   = 12;
   localparam int TALL_ROWS     = 12;

   typedef enum {TEX_NOISE, TEX_FLAT, TEX_BINARY} texture_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;   // [7:0] pixel
   logic                  req_tuser  = 1'b0;  // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [7:0] magnitude, [18:8] centre_x,
                                              // [30:19] centre_y, [31] zero
   logic                  rsp_tlast;          // frame_last
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CSR_FRAME_WIDTH;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   int mismatch_count;
   int edges_pending;
   int edges_checked;
   int pixels_seen;

   bit quiet        = 1'b0;  // no idling on either side once set
   bit tx_calm      = 1'b0;  // sender offers back to back while set
   int holdoff_left = 0;     // long receiver stall, counted down by the result side
   int cycle_count  = 0;

   sobel_edge_magnitude_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sobel_edge_magnitude_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .edges_pending  (edges_pending),
      .edges_checked  (edges_checked),
      .pixels_seen    (pixels_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, edges_pending);
         $display("sobel_edge_magnitude_top: mismatch");
         $finish;
      end
   end

   // Result side: random stall bursts, calm stretches, and the
   // long hold-off the stimulus asks for through holdoff_left
   initial begin : rsp_side
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (quiet || calm_left > 0) begin
            if (calm_left > 0) calm_left--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(40, 160);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            // a stall burst of random length, starting with this cycle
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic logic [PIX_W-1:0] texel(texture_type tex, int base);
      case (tex)
         TEX_FLAT:   return PIX_W'(base + $urandom_range(0, 3));
         TEX_BINARY: return ($urandom_range(0, 1) == 1) ? '1 : '0;
         default:    return PIX_W'($urandom());
      endcase
   endfunction

   // Offer one pixel request and hold it until the block takes it. Valid stays high
   // into the next request unless an idle burst is drawn.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
      if (!quiet && !tx_calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // A run of pixels of one texture; mark the first one as frame start if asked
   task automatic send_run(input int count, input logic mark, input texture_type tex);
      int base;
      base = $urandom_range(0, 252);
      for (int i = 0; i < count; i++) send_pixel(texel(tex, base), mark && i == 0);
   endtask

   // Drop valid, wait for every predicted result, then let a border pixel finish too
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (edges_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both size registers on back to back cycles
   task automatic set_size(input int w, input int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= CSR_W'(w);
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= CSR_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int          wr_w, wr_h, eff_w, eff_h, frames, count, cut, random_sent;
      logic        mark;
      texture_type tex;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: a short run on row 0, then shrink to 3x3 so the row ends at the
      // current column; any other width out of reset shows up as a misplaced result
      send_run(8, 1'b1, TEX_NOISE);
      wait_idle();
      set_size(3, 3);
      send_run(9, 1'b0, TEX_NOISE);
      wait_idle();

      // Directed: zero sizes clamp to 3x3
      set_size(0, 0);
      // dark left, bright right column: gradient saturates
      for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? '1 : '0, i == 0);
      // a lone marked pixel, abandoned by the next frame start
      send_pixel('1, 1'b1);
      // vertical ramp 10/20/30: small exact root
      for (int i = 0; i < 9; i++) send_pixel(PIX_W'(10 * (i / 3 + 1)), i == 0);
      // all white, no mark: the counters must wrap on their own
      for (int i = 0; i < 9; i++) send_pixel('1, 1'b0);
      wait_idle();

      // Directed: shrink both sizes mid frame, the current row and frame end early
      set_size(5, 4);
      send_run(6, 1'b1, TEX_NOISE);
      wait_idle();
      set_size(3, 3);
      send_run(5, 1'b0, TEX_NOISE);
      wait_idle();

      // Back pressure: hold off results long enough that the block stalls requests,
      // then pause the sender until every result is out
      set_size(4, 12);
      holdoff_left = 400;
      send_run(48, 1'b1, TEX_NOISE);
      wait_idle();

      // Width register above range clamps to the line store size; a short border run
      set_size(4095, 3);
      send_run(WIDE_PIXELS, 1'b1, TEX_NOISE);
      wait_idle();

      // Height register above range clamps to 4096 rows; a narrow run of a few rows
      set_size(3, 8191);
      send_run(3 * TALL_ROWS, 1'b1, TEX_FLAT);
      wait_idle();

      // Exact upper limits, a few border pixels only
      set_size(MAX_ROW_PIXELS, MAX_FRAME_ROWS);
      send_run(5, 1'b1, TEX_BINARY);
      wait_idle();

      // Random small frames. Each new size starts with a marked frame so no row reads
      // a line store column this frame has not written; mid-frame changes only shrink.
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent >= QUIET_FROM) quiet = 1'b1;
         case ($urandom_range(0, 7))
            0:       wr_w = $urandom_range(0, 2);
            1:       wr_w = $urandom_range(13, 24);
            default: wr_w = $urandom_range(3, 12);
         endcase
         wr_h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         eff_w = clamp(wr_w, 3, MAX_ROW_PIXELS);
         eff_h = clamp(wr_h, 3, MAX_FRAME_ROWS);
         set_size(wr_w, wr_h);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tex     = texture_type'($urandom_range(0, 2));
            mark    = (f == 0) || ($urandom_range(0, 1) == 1);
            count   = eff_w * eff_h;
            case ($urandom_range(0, 7))
               0: begin
                  // cut the frame short; what follows may or may not restart it
                  count = $urandom_range(1, count - 1);
                  send_run(count, mark, tex);
               end
               1: begin
                  if (eff_w > 3 || eff_h > 3) begin
                     // shrink the sizes part way through the frame
                     cut = $urandom_range(1, count - 1);
                     send_run(cut, mark, tex);
                     wait_idle();
                     eff_w = $urandom_range(3, eff_w);
                     eff_h = $urandom_range(3, eff_h);
                     set_size(eff_w, eff_h);
                     send_run(count - cut, 1'b0, tex);
                  end else begin
                     send_run(count, mark, tex);
                  end
               end
               default: send_run(count, mark, tex);
            endcase
            random_sent += count;
         end
         wait_idle();
      end
      tx_calm = 1'b0;

      // Everything offered; wait_idle above has drained the pipe with a margin
      wait_idle();
      $display("covered %0d pixel requests and %0d edge results on frames from 3x3 to 24 wide,",
               pixels_seen, edges_checked);
      $display("with restarts, wraps, clamped and shrunk sizes and a long result stall; %0d failed, %0d due",
               mismatch_count, edges_pending);
      if (mismatch_count == 0 && edges_pending == 0) begin
         $display("sobel_edge_magnitude_top: match");
      end else begin
         $display("sobel_edge_magnitude_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/sem_pkg.sv
hdl/sem_ctrl.sv
hdl/sem_dp.sv
hdl/sobel_edge_magnitude_top.sv
hdl/sem_checker.sv
verif/sobel_edge_magnitude_checker.sv
verif/tb_sobel_edge_magnitude_top.sv
